// ===== rtl/pcm_voice_player_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// PCM voice player assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef PCM_VOICE_PLAYER_MIXER_MACROS_SVH
`define PCM_VOICE_PLAYER_MIXER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PVPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pvpm assertion failed");

// A condition that must never be true outside reset.
`define PVPM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pvpm forbidden condition seen");

`endif

// ===== rtl/pvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM voice player package
// Types, codes and the pan gain table shared by the voice player modules.
// ----------------------------------------------------------------------------
package pvpm_pkg;

  localparam int unsigned Voices    = 16;
  localparam int unsigned VoiceBits = $clog2(Voices);
  localparam int unsigned PanMax    = 32;

  localparam logic [2:0]  ShiftReset = 3'd6;
  localparam logic [19:0] RatioReset = 20'd572167;

  typedef enum logic [1:0] {
    FUNC_CMD    = 2'd0,
    FUNC_ADV    = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_MIXOUT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    VREG_BANK   = 3'd0,
    VREG_START  = 3'd1,
    VREG_PITCH  = 3'd2,
    VREG_UNUSED = 3'd3,
    VREG_LOOP   = 3'd4,
    VREG_END    = 3'd5,
    VREG_VOLUME = 3'd6,
    VREG_SPARE  = 3'd7
  } vreg_e;

  typedef enum logic {
    CFG_SHIFT = 1'b0,
    CFG_RATIO = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MIX1,
    ST_MIX2
  } state_e;

  localparam logic [3:0] PanCmdHi = 4'h8;

  typedef struct packed {
    logic [6:0]        bank;
    logic [16:0]       addr;
    logic [19:0]       step;
    logic [15:0]       loop_len;
    logic [15:0]       end_addr;
    logic [15:0]       volume;
    logic [5:0]        pan_idx;
    logic              pan_set;
    logic              on;
    logic signed [7:0] last;
    logic [20:0]       phase;
    logic              pending;
  } voice_t;

  localparam int unsigned VoiceW = $bits(voice_t);

  function automatic logic [8:0] pan_gain(input logic [5:0] idx);
    logic [8:0] g;
    case (idx)
      6'd0:  g = 9'd0;   6'd1:  g = 9'd45;  6'd2:  g = 9'd64;  6'd3:  g = 9'd78;
      6'd4:  g = 9'd90;  6'd5:  g = 9'd101; 6'd6:  g = 9'd110; 6'd7:  g = 9'd119;
      6'd8:  g = 9'd128; 6'd9:  g = 9'd135; 6'd10: g = 9'd143; 6'd11: g = 9'd150;
      6'd12: g = 9'd156; 6'd13: g = 9'd163; 6'd14: g = 9'd169; 6'd15: g = 9'd175;
      6'd16: g = 9'd181; 6'd17: g = 9'd186; 6'd18: g = 9'd192; 6'd19: g = 9'd197;
      6'd20: g = 9'd202; 6'd21: g = 9'd207; 6'd22: g = 9'd212; 6'd23: g = 9'd217;
      6'd24: g = 9'd221; 6'd25: g = 9'd226; 6'd26: g = 9'd230; 6'd27: g = 9'd235;
      6'd28: g = 9'd239; 6'd29: g = 9'd243; 6'd30: g = 9'd247; 6'd31: g = 9'd251;
      6'd32: g = 9'd256;
      default: g = 9'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/pvpm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module pvpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcm_voice_player_mixer.sv =====
// ----------------------------------------------------------------------------
// PCM voice player and stereo mixer
// Sixteen voices of signed 8-bit PCM, pitch stepping, pan and volume mixing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         tdata: func, command, value, voice, rom_byte
//  m_axis    out        tuser: result_kind; tdata: fetch request or stereo mix
//  apb       in/out     volume_shift at 0x0, pitch_ratio at 0x4
//
// The voice entry of an item is read from the voice RAM in the accept cycle
// and modified and written back in the execute state. An item that mixes a
// voice then goes through ST_MIX1 and ST_MIX2 for the two chained multiplies.
// A result waits in the output register; the execute cycle holds while that
// register is still full. Reset clears the per-voice valid bits at once, so an
// unwritten voice reads as all zero and no clearing pass is needed.
module pcm_voice_player_mixer
  import pvpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0], command[9:2], value[25:10], voice[29:26], rom_byte[37:30]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fetch_address[23:0], fetch_voice[27:24], left_out[43:28], right_out[59:44]
  output logic [63:0] m_axis_tdata,
  // result_kind[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [2:0]  shift_q;
  logic [19:0] ratio_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
      ratio_q <= RatioReset;
    end else if (cfg_we) begin
      if (cfg_e'(paddr[2]) == CFG_SHIFT) begin
        shift_q <= pwdata[2:0];
      end else begin
        ratio_q <= pwdata[19:0];
      end
    end
  end

  assign prdata = (cfg_e'(paddr[2]) == CFG_SHIFT) ? {29'd0, shift_q} : {12'd0, ratio_q};

  // Input fields.
  logic [1:0]  in_func;
  logic [7:0]  in_cmd;
  logic [3:0]  in_voice;
  logic [VoiceBits-1:0] in_target;

  assign in_func  = s_axis_tdata[1:0];
  assign in_cmd   = s_axis_tdata[9:2];
  assign in_voice = s_axis_tdata[29:26];

  // The bank register of a voice is written through the command slot of the
  // voice before it, so that target is bumped by one here.
  always_comb begin
    if (func_e'(in_func) == FUNC_CMD) begin
      if (in_cmd[7]) begin
        in_target = in_cmd[VoiceBits-1:0];
      end else if (vreg_e'(in_cmd[2:0]) == VREG_BANK) begin
        in_target = VoiceBits'(in_cmd[6:3] + 4'd1);
      end else begin
        in_target = in_cmd[VoiceBits+2:3];
      end
    end else begin
      in_target = in_voice[VoiceBits-1:0];
    end
  end

  // Latched item.
  state_e state_q, state_d;
  logic        accept;
  func_e       func_q;
  logic [7:0]  cmd_q;
  logic [15:0] value_q;
  logic [VoiceBits-1:0] target_q;
  logic signed [7:0] rom_q;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(in_func);
      cmd_q    <= in_cmd;
      value_q  <= s_axis_tdata[25:10];
      target_q <= in_target;
      rom_q    <= s_axis_tdata[37:30];
    end
  end

  // Voice RAM with per-entry valid bits.
  logic [Voices-1:0]    valid_q;
  logic                 valid_rd_q;
  logic [VoiceBits-1:0] raddr;
  logic [VoiceW-1:0]    rdata;
  logic                 ram_we;
  voice_t               ent, nxt;

  assign raddr = (state_q == ST_IDLE) ? in_target : target_q;

  pvpm_ram #(.Width(VoiceW), .Depth(Voices)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (target_q),
    .wdata_i (nxt),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[target_q] <= 1'b1;
      end
      valid_rd_q <= valid_q[raddr];
    end
  end

  assign ent = valid_rd_q ? voice_t'(rdata) : '0;

  // Execute: modify the entry and decide on a result.
  logic        out_free;
  logic        emit_fetch, emit_mix, mix_go, do_write, stall;
  logic [35:0] pitch_prod;
  logic [4:0]  count;
  logic [16:0] addr_step;
  logic [5:0]  pan_raw;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign pitch_prod = 36'(value_q) * 36'(ratio_q);
  assign count      = ent.phase[20:16];
  assign addr_step  = 17'(ent.addr + 17'(count));
  assign pan_raw    = 6'(value_q - 16'h10);

  always_comb begin
    nxt        = ent;
    emit_fetch = 1'b0;
    emit_mix   = 1'b0;
    mix_go     = 1'b0;
    do_write   = 1'b0;
    case (func_q)
      FUNC_CMD: begin
        do_write = 1'b1;
        if (cmd_q[7:4] == PanCmdHi) begin
          nxt.pan_idx = (pan_raw > 6'(PanMax)) ? 6'(PanMax) : pan_raw;
          nxt.pan_set = 1'b1;
        end else if (!cmd_q[7]) begin
          case (vreg_e'(cmd_q[2:0]))
            VREG_BANK:  nxt.bank = value_q[6:0];
            VREG_START: nxt.addr = {1'b0, value_q};
            VREG_PITCH: begin
              nxt.step = pitch_prod[35:16];
              if (value_q == '0) begin
                nxt.on      = 1'b0;
                nxt.pending = 1'b0;
              end
            end
            VREG_LOOP: nxt.loop_len = value_q;
            VREG_END:  nxt.end_addr = value_q;
            VREG_VOLUME: begin
              if (value_q == '0) begin
                nxt.on      = 1'b0;
                nxt.pending = 1'b0;
              end else if (!ent.on) begin
                nxt.on      = 1'b1;
                nxt.phase   = '0;
                nxt.last    = '0;
                nxt.pending = 1'b0;
              end
              nxt.volume = value_q;
            end
            default: do_write = 1'b0;
          endcase
        end else begin
          do_write = 1'b0;
        end
      end
      FUNC_ADV: begin
        if (ent.on) begin
          if (ent.pending) begin
            emit_fetch = 1'b1;
          end else begin
            do_write = 1'b1;
            if (count == '0) begin
              nxt.phase = 21'(ent.phase[15:0]) + 21'(ent.step);
              mix_go    = 1'b1;
            end else begin
              nxt.phase = 21'(ent.phase[15:0]);
              nxt.addr  = addr_step;
              // A voice that keys off at its end keeps the address it reached.
              if (addr_step >= {1'b0, ent.end_addr} && ent.loop_len != '0) begin
                nxt.addr = {1'b0, 16'(ent.end_addr - ent.loop_len)};
              end
              if (addr_step >= {1'b0, ent.end_addr} && ent.loop_len == '0) begin
                nxt.on = 1'b0;
              end else begin
                nxt.pending = 1'b1;
                emit_fetch  = 1'b1;
              end
            end
          end
        end
      end
      FUNC_SAMPLE: begin
        if (ent.on && ent.pending) begin
          do_write    = 1'b1;
          nxt.pending = 1'b0;
          nxt.last    = rom_q;
          nxt.phase   = 21'(ent.phase + 21'(ent.step));
          mix_go      = 1'b1;
        end
      end
      default: emit_mix = 1'b1;
    endcase
  end

  assign stall = (emit_fetch || emit_mix) && !out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: begin
        if (!stall) begin
          state_d = mix_go ? ST_MIX1 : ST_IDLE;
        end
      end
      ST_MIX1: state_d = ST_MIX2;
      ST_MIX2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: ram_we = do_write && !stall;
      default: begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Mix path: gain times volume, shifted, then times the sample.
  logic [8:0]  gain_l_q, gain_r_q;
  logic [15:0] vol_q;
  logic signed [7:0] smp_q;
  logic [24:0] scaled_l_q, scaled_r_q;
  logic [24:0] gv_l, gv_r;
  logic signed [33:0] prod_l, prod_r;
  logic signed [31:0] acc_l_q, acc_r_q;
  logic        mix_load, mixout_fire;

  assign mix_load    = (state_q == ST_EXEC) && mix_go;
  assign mixout_fire = (state_q == ST_EXEC) && emit_mix && out_free;

  always_ff @(posedge clk_i) begin
    if (mix_load) begin
      gain_l_q <= ent.pan_set ? pan_gain(6'(PanMax) - nxt.pan_idx) : '0;
      gain_r_q <= ent.pan_set ? pan_gain(nxt.pan_idx) : '0;
      vol_q    <= nxt.volume;
      smp_q    <= nxt.last;
    end
    if (state_q == ST_MIX1) begin
      scaled_l_q <= gv_l >> shift_q;
      scaled_r_q <= gv_r >> shift_q;
    end
  end

  assign gv_l   = 25'(gain_l_q) * 25'(vol_q);
  assign gv_r   = 25'(gain_r_q) * 25'(vol_q);
  assign prod_l = 34'(smp_q) * $signed({9'd0, scaled_l_q});
  assign prod_r = 34'(smp_q) * $signed({9'd0, scaled_r_q});

  // Accumulators wrap at 32 bits; they are cleared when a mix is sent out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (mixout_fire) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (state_q == ST_MIX2) begin
      acc_l_q <= acc_l_q + 32'(prod_l >>> 6);
      acc_r_q <= acc_r_q + 32'(prod_r >>> 6);
    end
  end

  function automatic logic [15:0] sat16(input logic signed [31:0] a);
    logic [15:0] r;
    if (a > 32'sd32767) begin
      r = 16'h7fff;
    end else if (a < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

  // Output register.
  logic        out_valid_q;
  logic        kind_q;
  logic [59:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EXEC && (emit_fetch || emit_mix) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // A fresh fetch carries the address the voice has just moved to.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && out_free) begin
      if (emit_fetch) begin
        kind_q     <= 1'b0;
        out_data_q <= {32'd0, 4'(target_q),
                       24'({nxt.bank, 16'd0}) + 24'(nxt.addr)};
      end else if (emit_mix) begin
        kind_q     <= 1'b1;
        out_data_q <= {sat16(acc_r_q), sat16(acc_l_q), 28'd0};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

`include "pcm_voice_player_mixer_macros.svh"

  // The voice RAM is only written back from the execute cycle.
  `PVPM_NEVER(a_we_exec, ram_we && state_q != ST_EXEC)
  // An accepted item always moves straight to its execute cycle.
  `PVPM_ASSERT(a_accept_exec, accept |=> state_q == ST_EXEC)
  // A mix sent out leaves both accumulators cleared.
  `PVPM_ASSERT(a_mixout_clear, mixout_fire |=> (acc_l_q == '0 && acc_r_q == '0))

endmodule
